// ----- hdl/x917p_pkg.sv -----
// x917p_pkg: shared types, aes s-box table and aes round and key step functions
// for the x9.17 random generator; no dependencies
`default_nettype none
package x917p_pkg;

  localparam int unsigned CoarseTimeBitsDef = 32;
  localparam int unsigned FineTimeBitsDef   = 32;
  localparam int unsigned BlockBits         = 128;
  localparam int unsigned CountBits         = 5;
  localparam int unsigned InDataBits        = 328;
  localparam int unsigned OutDataBits       = 136;
  localparam logic [CountBits-1:0] MaxBytes = 5'd16;
  localparam logic [CountBits-1:0] MinBytes = 5'd1;
  localparam logic [3:0] LastRound          = 4'd10;
  localparam logic [7:0] RconInit           = 8'h01;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_RESEED   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_I,
    ST_WAIT_I,
    ST_ENC_R,
    ST_WAIT_R,
    ST_ENC_V,
    ST_WAIT_V,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [BlockBits-1:0] key;
    logic [BlockBits-1:0] blk;
  } aes_req_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i down
  function automatic logic [BlockBits-1:0] aes_round(input logic [BlockBits-1:0] s,
                                                      input logic [BlockBits-1:0] rk,
                                                      input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] x;
    logic [BlockBits-1:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r+4*c] = SBOX[b[r+4*((c+r)%4)]];
    for (int c = 0; c < 4; c++) begin
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    aes_round = o;
  endfunction

  function automatic logic [BlockBits-1:0] key_step(input logic [BlockBits-1:0] k,
                                                     input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/x917_prng_aes128_core.sv -----
// x917_prng_aes128_core: x9.17 random generator top level, sequencer and state
// depends on x917p_pkg and x917p_aes
// usage:
//   s_axis takes one request; tuser is the operation (0 generate, 1 reseed)
//   and tdata packs the timer fields, byte count and 256-bit seed.
//   m_axis returns one transaction per request: the random block and the
//   count of valid leading bytes, or all zeros as a reseed acknowledge.
//   a generate or a seeded reseed runs three aes-128 encryptions in turn on
//   one round unit (load, ten rounds, hand-off each) before the result is offered;
//   a first reseed offers its acknowledge in the cycle after accept.
//   the round unit is the single shared resource; one request is in flight
//   at a time and s_axis_tready is high only while idle, so a new request is
//   accepted only after the last result has been taken.
//   the result is held in an output register until m_axis_tready; a stalled
//   receiver holds off the next request.
//   reset clears key, chaining value and the seeded flag to zero.
`default_nettype none
module x917_prng_aes128_core #(
  parameter int unsigned COARSE_TIME_BITS = x917p_pkg::CoarseTimeBitsDef,
  parameter int unsigned FINE_TIME_BITS   = x917p_pkg::FineTimeBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // operation
  input  wire logic                               s_axis_tuser,
  // coarse_time, fine_time, bytes_wanted, seed_key_hi, seed_key_lo, seed_v_hi, seed_v_lo
  input  wire logic [x917p_pkg::InDataBits-1:0]   s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // random_hi, random_lo, valid_bytes
  output logic [x917p_pkg::OutDataBits-1:0]       m_axis_tdata
);

  localparam int unsigned CB = (COARSE_TIME_BITS + 7) / 8;
  localparam int unsigned FB = (FINE_TIME_BITS + 7) / 8;

  x917p_pkg::state_e state_q, state_d;
  logic [x917p_pkg::BlockBits-1:0] key_q, v_q, dt_q, i_q, r_q, sk_q, sv_q, out_r_q;
  logic [x917p_pkg::CountBits-1:0] nb_q, out_n_q, nb_in;
  logic seeded_q, op_q;
  logic in_acc, out_acc;
  logic [x917p_pkg::BlockBits-1:0] dt_in, aes_res;
  logic [63:0] c64, f64;
  logic aes_done;
  x917p_pkg::aes_req_t aes_req;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    c64 = {32'd0, s_axis_tdata[31:0]};
    f64 = {32'd0, s_axis_tdata[63:32]};
    for (int i = 0; i < 64; i++) begin
      if (i >= COARSE_TIME_BITS) c64[i] = 1'b0;
      if (i >= FINE_TIME_BITS) f64[i] = 1'b0;
    end
    dt_in = '0;
    for (int k = 0; k < 16; k++) begin
      if (k < CB) dt_in[127-8*k -: 8] = c64[8*k +: 8];
      else if (k - CB < FB) dt_in[127-8*k -: 8] = f64[8*(k-CB) +: 8];
    end
  end

  always_comb begin
    if (s_axis_tdata[68:64] == 5'd0) nb_in = x917p_pkg::MinBytes;
    else if (s_axis_tdata[68:64] > x917p_pkg::MaxBytes) nb_in = x917p_pkg::MaxBytes;
    else nb_in = s_axis_tdata[68:64];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      x917p_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == x917p_pkg::OP_RESEED && !seeded_q) state_d = x917p_pkg::ST_OUT;
          else state_d = x917p_pkg::ST_ENC_I;
        end
      end
      x917p_pkg::ST_ENC_I:  state_d = x917p_pkg::ST_WAIT_I;
      x917p_pkg::ST_WAIT_I: if (aes_done) state_d = x917p_pkg::ST_ENC_R;
      x917p_pkg::ST_ENC_R:  state_d = x917p_pkg::ST_WAIT_R;
      x917p_pkg::ST_WAIT_R: if (aes_done) state_d = x917p_pkg::ST_ENC_V;
      x917p_pkg::ST_ENC_V:  state_d = x917p_pkg::ST_WAIT_V;
      x917p_pkg::ST_WAIT_V: if (aes_done) state_d = x917p_pkg::ST_OUT;
      x917p_pkg::ST_OUT:    if (m_axis_tready) state_d = x917p_pkg::ST_IDLE;
      default:              state_d = x917p_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    aes_req.start = 1'b0;
    aes_req.key   = key_q;
    aes_req.blk   = dt_q;
    unique case (state_q)
      x917p_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      x917p_pkg::ST_ENC_I: aes_req.start = 1'b1;
      x917p_pkg::ST_ENC_R: begin
        aes_req.start = 1'b1;
        aes_req.blk   = i_q ^ v_q;
      end
      x917p_pkg::ST_ENC_V: begin
        aes_req.start = 1'b1;
        aes_req.blk   = r_q ^ i_q;
      end
      x917p_pkg::ST_OUT:   m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  x917p_aes u_aes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (aes_req),
    .done_o   (aes_done),
    .result_o (aes_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= x917p_pkg::ST_IDLE;
      seeded_q <= 1'b0;
      key_q    <= '0;
      v_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && s_axis_tuser == x917p_pkg::OP_RESEED && !seeded_q) begin
        seeded_q <= 1'b1;
        key_q    <= {s_axis_tdata[132:69], s_axis_tdata[196:133]};
        v_q      <= {s_axis_tdata[260:197], s_axis_tdata[324:261]};
      end
      if (state_q == x917p_pkg::ST_WAIT_V && aes_done) begin
        if (op_q == x917p_pkg::OP_RESEED) begin
          key_q <= r_q ^ sk_q;
          v_q   <= aes_res ^ sv_q;
        end else begin
          v_q <= aes_res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= s_axis_tuser;
      dt_q    <= dt_in;
      nb_q    <= nb_in;
      sk_q    <= {s_axis_tdata[132:69], s_axis_tdata[196:133]};
      sv_q    <= {s_axis_tdata[260:197], s_axis_tdata[324:261]};
      out_r_q <= '0;
      out_n_q <= '0;
    end
    if (state_q == x917p_pkg::ST_WAIT_I && aes_done) i_q <= aes_res;
    if (state_q == x917p_pkg::ST_WAIT_R && aes_done) r_q <= aes_res;
    if (state_q == x917p_pkg::ST_WAIT_V && aes_done) begin
      if (op_q == x917p_pkg::OP_GENERATE) begin
        out_r_q <= r_q;
        out_n_q <= nb_q;
      end else begin
        out_r_q <= '0;
        out_n_q <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'd0, out_n_q, out_r_q[63:0], out_r_q[127:64]};

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(seeded_q))
    else $error("seeded flag cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done |-> (state_q == x917p_pkg::ST_WAIT_I || state_q == x917p_pkg::ST_WAIT_R ||
                  state_q == x917p_pkg::ST_WAIT_V))
    else $error("cipher finished outside a wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_n_q == 5'd0) |-> (op_q == x917p_pkg::OP_RESEED))
    else $error("zero byte count on a generate result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> s_axis_tready)
    else $error("not idle after result taken");

endmodule
`default_nettype wire

// ----- hdl/x917p_aes.sv -----
// x917p_aes: iterative aes-128 encryptor, one round per cycle with on-the-fly key schedule
// depends on x917p_pkg
`default_nettype none
module x917p_aes (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire x917p_pkg::aes_req_t            req_i,
  output logic                                done_o,
  output logic [x917p_pkg::BlockBits-1:0]     result_o
);

  logic [x917p_pkg::BlockBits-1:0] st_q, st_d, rk_q, rk_d, rk_n;
  logic [7:0] rcon_q, rcon_d;
  logic [3:0] rnd_q, rnd_d;
  logic       run_q, run_d, done_q, done_d;

  assign rk_n = x917p_pkg::key_step(rk_q, rcon_q);

  always_comb begin
    st_d   = st_q;
    rk_d   = rk_q;
    rcon_d = rcon_q;
    rnd_d  = rnd_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      st_d   = req_i.blk ^ req_i.key;
      rk_d   = req_i.key;
      rcon_d = x917p_pkg::RconInit;
      rnd_d  = 4'd1;
      run_d  = 1'b1;
    end else if (run_q) begin
      st_d   = x917p_pkg::aes_round(st_q, rk_n, rnd_q == x917p_pkg::LastRound);
      rk_d   = rk_n;
      rcon_d = x917p_pkg::xtime(rcon_q);
      rnd_d  = rnd_q + 4'd1;
      if (rnd_q == x917p_pkg::LastRound) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 4'd0;
      rcon_q <= 8'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
  end

  assign done_o   = done_q;
  assign result_o = st_q;

endmodule
`default_nettype wire

// ----- sim/x917_prng_checker.sv -----
// x917_prng_checker: watches both stream channels of the x9.17 generator,
// predicts each result with its own aes-128 model and compares; uses x917p_pkg
`default_nettype none
module x917_prng_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic                             s_axis_tuser,
  input  wire logic [x917p_pkg::InDataBits-1:0]  s_axis_tdata,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [x917p_pkg::OutDataBits-1:0] m_axis_tdata,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  logic [7:0] sb [256];
  logic [127:0] key_q, chain_q;
  logic seeded_q;
  logic [135:0] block_fifo [$];

  initial begin
    sb = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
  end

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block is bits 127-8n down
  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, rc, a0, a1, a2, a3, x;
    logic [127:0] o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = w[0];
        w[0] = sb[w[1]] ^ rc;
        w[1] = sb[w[2]];
        w[2] = sb[w[3]];
        w[3] = sb[f];
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) t[r+4*c] = sb[s[r+4*((c+r)%4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  // one x9.17 step; advances the chaining value
  function automatic logic [127:0] x917_step(input logic [31:0] coarse,
                                             input logic [31:0] fine);
    logic [127:0] dt, ival, r;
    dt = '0;
    for (int k = 0; k < 4; k++) begin
      dt[127-8*k -: 8] = coarse[8*k +: 8];
      dt[127-8*(4+k) -: 8] = fine[8*k +: 8];
    end
    ival = encrypt_block(key_q, dt);
    r = encrypt_block(key_q, ival ^ chain_q);
    chain_q = encrypt_block(key_q, r ^ ival);
    return r;
  endfunction

  task automatic predict_request(input logic op, input logic [327:0] d);
    logic [31:0] coarse, fine;
    logic [4:0] nb;
    logic [127:0] skey, sv, r;
    coarse = d[31:0];
    fine = d[63:32];
    nb = d[68:64];
    skey = {d[132:69], d[196:133]};
    sv = {d[260:197], d[324:261]};
    if (op == x917p_pkg::OP_RESEED) begin
      if (!seeded_q) begin
        key_q = skey;
        chain_q = sv;
        seeded_q = 1'b1;
      end else begin
        r = x917_step(coarse, fine);
        key_q = r ^ skey;
        chain_q = chain_q ^ sv;
      end
      block_fifo.push_back('0);
    end else begin
      if (nb == 0) nb = x917p_pkg::MinBytes;
      if (nb > x917p_pkg::MaxBytes) nb = x917p_pkg::MaxBytes;
      r = x917_step(coarse, fine);
      block_fifo.push_back({3'b0, nb, r});
    end
  endtask

  initial begin
    key_q = '0;
    chain_q = '0;
    seeded_q = 1'b0;
    fail_count_o = 0;
  end

  assign pending_o = block_fifo.size();

  always @(posedge clk_i) begin
    logic [135:0] exp_blk;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (block_fifo.size() == 0) begin
          $error("unexpected transaction %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          exp_blk = block_fifo.pop_front();
          if (m_axis_tdata[63:0] !== exp_blk[127:64]) begin
            $error("random_hi exp %h got %h", exp_blk[127:64], m_axis_tdata[63:0]);
            fail_count_o++;
          end
          if (m_axis_tdata[127:64] !== exp_blk[63:0]) begin
            $error("random_lo exp %h got %h", exp_blk[63:0], m_axis_tdata[127:64]);
            fail_count_o++;
          end
          if (m_axis_tdata[135:128] !== {3'b0, exp_blk[132:128]}) begin
            $error("valid_bytes exp %0d got %0d", exp_blk[132:128], m_axis_tdata[135:128]);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sim/tb_x917_prng_aes128_core.sv -----
// tb_x917_prng_aes128_core: drives generate and reseed requests with random
// idling on both channels; depends on x917p_pkg, the core and x917_prng_checker
`default_nettype none
module tb_x917_prng_aes128_core;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [x917p_pkg::InDataBits-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [x917p_pkg::OutDataBits-1:0] m_axis_tdata;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;

  x917_prng_aes128_core DUT (.*);

  x917_prng_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("x917_prng_aes128_core verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // leaves tvalid high after the accepting edge; the next call reloads or drops it, or the caller drops it
  task automatic send_request(input logic op, input logic [31:0] coarse,
                              input logic [31:0] fine, input logic [4:0] nb,
                              input logic [127:0] skey, input logic [127:0] sv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b0, sv[63:0], sv[127:64], skey[63:0], skey[127:64], nb, fine, coarse};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [4:0] nb;
    nb = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(16, 1));
    send_request(($urandom_range(9) == 0) ? x917p_pkg::OP_RESEED : x917p_pkg::OP_GENERATE,
                 rand_time(), rand_time(), nb, {rand64(), rand64()}, {rand64(), rand64()});
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // unseeded generates, byte count extremes
    send_request(x917p_pkg::OP_GENERATE, '0, '0, 5'd1, '0, '0);
    send_request(x917p_pkg::OP_GENERATE, '1, '1, 5'd16, '1, '1);
    send_request(x917p_pkg::OP_GENERATE, 32'h01234567, 32'h89abcdef, 5'd0, '0, '0);
    send_request(x917p_pkg::OP_GENERATE, '1, '0, 5'd31, '0, '0);
    send_request(x917p_pkg::OP_GENERATE, '0, '1, 5'd17, '0, '0);
    // first reseed, then seeded reseeds
    send_request(x917p_pkg::OP_RESEED, '1, '1, 5'd7, '1, '0);
    send_request(x917p_pkg::OP_GENERATE, '0, '0, 5'd8, '0, '1);
    send_request(x917p_pkg::OP_RESEED, '0, '0, 5'd0, '0, '1);
    send_request(x917p_pkg::OP_RESEED, '1, '1, 5'd31, '1, '1);
    for (int n = 1; n <= 16; n++)
      send_request(x917p_pkg::OP_GENERATE, $urandom(), $urandom(), 5'(n), '0, '0);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 200; i++) begin
        send_random();
        if (i == 100) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("x917_prng_aes128_core verification clean");
    end else begin
      $display("x917_prng_aes128_core verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- x917_prng_aes128_core.f -----
hdl/x917p_pkg.sv
hdl/x917p_aes.sv
hdl/x917_prng_aes128_core.sv
sim/x917_prng_checker.sv
sim/tb_x917_prng_aes128_core.sv
